@@ rtl/gcp_pkg.sv @@
// Grid cell partition: shared widths, register indexes, command/status types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package gcp_pkg;

    localparam int CountW   = 9;
    localparam int LatW     = 31;
    localparam int LonW     = 32;
    localparam int CoordW   = 32;
    localparam int IdxW     = 8;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;
    localparam int DvdW     = 32;
    localparam int DvsW     = 9;
    localparam int DivCntW  = 6;
    localparam int TrialW   = 5;
    localparam int OutW     = 4 * CoordW + 2 * IdxW;

    localparam logic [CountW-1:0]  MaxAgents = 9'd256;
    localparam logic [DivCntW-1:0] TrialBits = 6'd9;
    localparam logic [DivCntW-1:0] SpanBits  = 6'd32;
    localparam logic [DivCntW-1:0] IndexBits = 6'd8;

    localparam logic [CfgIdxW-1:0] CFG_AGENT_COUNT = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_NORTH_LAT   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_WEST_LON    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_SOUTH_LAT   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_EAST_LON    = 3'd4;

    typedef enum logic [1:0] {
        DIV_TRIAL  = 2'd0,
        DIV_HEIGHT = 2'd1,
        DIV_WIDTH  = 2'd2,
        DIV_INDEX  = 2'd3
    } div_sel_t;

    typedef struct packed {
        logic     load_item;
        logic     div_start;
        div_sel_t div_sel;
        logic     take_trial;
        logic     next_trial;
        logic     take_height;
        logic     take_width;
        logic     take_index;
        logic     form_prod;
        logic     form_corner;
        logic     load_out;
    } gcp_cmd_t;

    typedef struct packed {
        logic single;
        logic trial_over;
        logic div_done;
        logic rem_zero;
        logic out_busy;
    } gcp_status_t;

endpackage

`default_nettype wire

@@ rtl/gcp_div.sv @@
// Shared restoring divider, one quotient bit per cycle over nbits bits.
// Depends on gcp_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module gcp_div import gcp_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [DvdW-1:0]    dividend,
    input  wire logic [DvsW-1:0]    divisor,
    input  wire logic [DivCntW-1:0] nbits,
    output logic                    done,
    output logic [DvdW-1:0]         quotient,
    output logic [DvsW-1:0]         remainder
);

    logic [DivCntW-1:0] cnt_reg;
    logic               done_reg;
    logic [DvdW-1:0]    dvd_reg;
    logic [DvsW-1:0]    dvs_reg;
    logic [DvsW-1:0]    rem_reg;
    logic [DvsW-1:0]    rem_next;
    logic [DvdW-1:0]    quo_reg;
    logic [DivCntW-1:0] cnt_m1;
    logic [DvsW:0]      trial;
    logic               ge;

    assign cnt_m1 = cnt_reg - 6'd1;
    assign trial  = {rem_reg, dvd_reg[cnt_m1[4:0]]};
    assign ge     = trial >= {1'b0, dvs_reg};

    always_comb begin
        if (ge) begin
            rem_next = DvsW'(trial - {1'b0, dvs_reg});
        end else begin
            rem_next = trial[DvsW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= nbits;
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg  <= cnt_m1;
            done_reg <= (cnt_reg == 6'd1);
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DvdW-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

@@ rtl/gcp_datapath.sv @@
// Datapath: region registers, divisor search operands, spans, products, output beat.
// Depends on gcp_pkg and gcp_div.
`timescale 1ns / 1ps
`default_nettype none

module gcp_datapath import gcp_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_wdata,
    input  wire logic [IdxW-1:0]     s_tdata,
    input  wire gcp_cmd_t            cmd,
    output gcp_status_t              status,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [OutW-1:0]          m_tdata
);

    logic [CountW-1:0] count_reg;
    logic [LatW-1:0]   nlat_reg;
    logic [LonW-1:0]   wlon_reg;
    logic [LatW-1:0]   slat_reg;
    logic [LonW-1:0]   elon_reg;

    logic [CountW-1:0] n_clamp;
    logic [CoordW-1:0] nlat32, slat32, span_lat, span_lon;

    logic [IdxW-1:0]   idx_reg;
    logic [CountW-1:0] n_reg;
    logic [CoordW-1:0] span_lat_reg, span_lon_reg;
    logic [TrialW-1:0] c_reg;
    logic [DvsW-1:0]   rows_reg, cols_reg;
    logic [CoordW-1:0] height_reg, width_reg;
    logic [IdxW-1:0]   row_reg, col_reg;
    logic [CoordW-1:0] prod_lat_reg, prod_lon_reg;
    logic [CoordW-1:0] nw_lat_reg, nw_lon_reg;
    logic              single_reg;
    logic              m_tvalid_reg;
    logic [OutW-1:0]   m_tdata_reg;

    logic [2*TrialW-1:0]   c_sq;
    logic [IdxW+CoordW-1:0] mul_lat, mul_lon;
    logic [CoordW-1:0]     south, east;
    logic [IdxW-1:0]       out_row, out_col;

    logic [DvdW-1:0]    div_dvd;
    logic [DvsW-1:0]    div_dvs;
    logic [DivCntW-1:0] div_bits;
    logic               div_done;
    logic [DvdW-1:0]    div_quo;
    logic [DvsW-1:0]    div_rem;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 9'd1;
            nlat_reg  <= '0;
            wlon_reg  <= '0;
            slat_reg  <= '0;
            elon_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_AGENT_COUNT: count_reg <= cfg_wdata[CountW-1:0];
                CFG_NORTH_LAT:   nlat_reg  <= cfg_wdata[LatW-1:0];
                CFG_WEST_LON:    wlon_reg  <= cfg_wdata[LonW-1:0];
                CFG_SOUTH_LAT:   slat_reg  <= cfg_wdata[LatW-1:0];
                CFG_EAST_LON:    elon_reg  <= cfg_wdata[LonW-1:0];
                default: ;
            endcase
        end
    end

    assign n_clamp = (count_reg > MaxAgents) ? MaxAgents : count_reg;
    assign nlat32  = {nlat_reg[LatW-1], nlat_reg};
    assign slat32  = {slat_reg[LatW-1], slat_reg};

    // absolute spans; exact differences fit 32 unsigned bits
    assign span_lat = ($signed(nlat_reg) < $signed(slat_reg)) ? (slat32 - nlat32)
                                                              : (nlat32 - slat32);
    assign span_lon = ($signed(wlon_reg) < $signed(elon_reg)) ? (elon_reg - wlon_reg)
                                                              : (wlon_reg - elon_reg);

    always_comb begin
        case (cmd.div_sel)
            DIV_TRIAL: begin
                div_dvd  = {{(DvdW-CountW){1'b0}}, n_reg};
                div_dvs  = {{(DvsW-TrialW){1'b0}}, c_reg};
                div_bits = TrialBits;
            end
            DIV_HEIGHT: begin
                div_dvd  = span_lat_reg;
                div_dvs  = rows_reg;
                div_bits = SpanBits;
            end
            DIV_WIDTH: begin
                div_dvd  = span_lon_reg;
                div_dvs  = cols_reg;
                div_bits = SpanBits;
            end
            DIV_INDEX: begin
                div_dvd  = {{(DvdW-IdxW){1'b0}}, idx_reg};
                div_dvs  = cols_reg;
                div_bits = IndexBits;
            end
            default: begin
                div_dvd  = '0;
                div_dvs  = cols_reg;
                div_bits = '0;
            end
        endcase
    end

    gcp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .nbits     (div_bits),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign c_sq    = {{TrialW{1'b0}}, c_reg} * {{TrialW{1'b0}}, c_reg};
    assign mul_lat = {{CoordW{1'b0}}, row_reg} * {{IdxW{1'b0}}, height_reg};
    assign mul_lon = {{CoordW{1'b0}}, col_reg} * {{IdxW{1'b0}}, width_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            idx_reg      <= s_tdata;
            n_reg        <= n_clamp;
            span_lat_reg <= span_lat;
            span_lon_reg <= span_lon;
            c_reg        <= 5'd1;
            rows_reg     <= 9'd1;
            cols_reg     <= n_clamp;
            single_reg   <= status.single;
        end else begin
            if (cmd.next_trial) begin
                c_reg <= c_reg + 5'd1;
            end
            if (cmd.take_trial) begin
                rows_reg <= {{(DvsW-TrialW){1'b0}}, c_reg};
                cols_reg <= div_quo[DvsW-1:0];
            end
        end
        if (cmd.take_height) begin
            height_reg <= div_quo;
        end
        if (cmd.take_width) begin
            width_reg <= div_quo;
        end
        if (cmd.take_index) begin
            row_reg <= div_quo[IdxW-1:0];
            col_reg <= div_rem[IdxW-1:0];
        end
        if (cmd.form_prod) begin
            prod_lat_reg <= mul_lat[CoordW-1:0];
            prod_lon_reg <= mul_lon[CoordW-1:0];
        end
        if (cmd.form_corner) begin
            if (single_reg) begin
                nw_lat_reg <= nlat32;
                nw_lon_reg <= wlon_reg;
            end else begin
                nw_lat_reg <= nlat32 - prod_lat_reg;
                nw_lon_reg <= wlon_reg + prod_lon_reg;
            end
        end
        if (cmd.load_out) begin
            m_tdata_reg <= {out_col, out_row, east, south, nw_lon_reg, nw_lat_reg};
        end
    end

    always_comb begin
        if (single_reg) begin
            south   = slat32;
            east    = elon_reg;
            out_row = '0;
            out_col = '0;
        end else begin
            south   = nw_lat_reg - height_reg;
            east    = nw_lon_reg + width_reg;
            out_row = row_reg;
            out_col = col_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign status.single     = (n_clamp <= 9'd1);
    assign status.trial_over = c_sq > {{(2*TrialW-CountW){1'b0}}, n_reg};
    assign status.div_done   = div_done;
    assign status.rem_zero   = (div_rem == '0);
    assign status.out_busy   = m_tvalid_reg & ~m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

@@ rtl/gcp_ctrl.sv @@
// Controller: sequences divisor search, span and index divisions, corner forming.
// Depends on gcp_pkg command and status types.
`timescale 1ns / 1ps
`default_nettype none

module gcp_ctrl import gcp_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire gcp_status_t status,
    output gcp_cmd_t         cmd
);

    typedef enum logic [8:0] {
        ST_IDLE       = 9'b000000001,
        ST_TRIAL      = 9'b000000010,
        ST_TRIAL_WAIT = 9'b000000100,
        ST_HT_WAIT    = 9'b000001000,
        ST_WD_WAIT    = 9'b000010000,
        ST_IX_WAIT    = 9'b000100000,
        ST_MUL        = 9'b001000000,
        ST_FORM       = 9'b010000000,
        ST_DONE       = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_TRIAL;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = status.single ? ST_FORM : ST_TRIAL;
                end
            end
            ST_TRIAL: begin
                cmd.div_start = 1'b1;
                if (status.trial_over) begin
                    cmd.div_sel = DIV_HEIGHT;
                    state_next  = ST_HT_WAIT;
                end else begin
                    state_next  = ST_TRIAL_WAIT;
                end
            end
            ST_TRIAL_WAIT: begin
                if (status.div_done) begin
                    cmd.next_trial = 1'b1;
                    cmd.take_trial = status.rem_zero;
                    state_next     = ST_TRIAL;
                end
            end
            ST_HT_WAIT: begin
                if (status.div_done) begin
                    cmd.take_height = 1'b1;
                    cmd.div_start   = 1'b1;
                    cmd.div_sel     = DIV_WIDTH;
                    state_next      = ST_WD_WAIT;
                end
            end
            ST_WD_WAIT: begin
                if (status.div_done) begin
                    cmd.take_width = 1'b1;
                    cmd.div_start  = 1'b1;
                    cmd.div_sel    = DIV_INDEX;
                    state_next     = ST_IX_WAIT;
                end
            end
            ST_IX_WAIT: begin
                if (status.div_done) begin
                    cmd.take_index = 1'b1;
                    state_next     = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.form_prod = 1'b1;
                state_next    = ST_FORM;
            end
            ST_FORM: begin
                cmd.form_corner = 1'b1;
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

@@ rtl/grid_cell_partition_core.sv @@
// Top level of the grid cell partition block: controller plus datapath.
// Depends on gcp_pkg, gcp_ctrl, gcp_datapath (and gcp_div below it).
//
//  channel  | direction | beat contents
//  s_       | in        | tdata[7:0] agent_index
//  m_       | out       | tdata: north_lat, west_lon, south_lat, east_lon, row, column
//  cfg_     | in        | index 0..4: agent_count, north, west, south, east
//
// One request runs a trial division for each c with c*c <= N (N = clamped agent count,
// at most 256); N of 0 or 1 skips all divisions. All divisions share one restoring divider
// that yields a quotient bit per cycle: 9-bit trial divisions, two 32-bit span
// divisions and one 8-bit index division. Reset is synchronous, active low.
// A finished beat sits in the output register; the next request is taken meanwhile
// and only its final load waits for m_tready.
`timescale 1ns / 1ps
`default_nettype none

module grid_cell_partition_core import gcp_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_wdata,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [IdxW-1:0]     s_tdata,   // [7:0] agent_index
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [31:0] cell_north_lat, [63:32] cell_west_lon, [95:64] cell_south_lat,
    // [127:96] cell_east_lon, [135:128] cell_row, [143:136] cell_column
    output logic [OutW-1:0]          m_tdata
);

    gcp_cmd_t    cmd;
    gcp_status_t status;

    gcp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gcp_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

@@ rtl/gcp_checker.sv @@
// Port-level checks on grid_cell_partition_core, attached by bind.
// Depends on gcp_pkg widths.
`timescale 1ns / 1ps
`default_nettype none

module gcp_checker import gcp_pkg::*; (
    input wire logic            aclk,
    input wire logic            aresetn,
    input wire logic            s_tvalid,
    input wire logic            s_tready,
    input wire logic            m_tvalid,
    input wire logic            m_tready,
    input wire logic [OutW-1:0] m_tdata
);

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("outputs not idle after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second beat taken while one is in work");

    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result beat appeared with no request in work");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output beat changed");

endmodule

bind grid_cell_partition_core gcp_checker u_gcp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
